[hw/rtl/xid_pkg.sv]
// Package for the x86 subset instruction decoder: beat types, mnemonic and
// operand form codes, and the queue entry passed from front to back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xid_pkg;

    localparam int HeldBytes = 7;
    localparam int QueueDepth = 2;

    localparam logic [4:0] MN_UNDEC  = 5'd0;
    localparam logic [4:0] MN_JE     = 5'd1;
    localparam logic [4:0] MN_JNE    = 5'd2;
    localparam logic [4:0] MN_JL     = 5'd3;
    localparam logic [4:0] MN_JG     = 5'd4;
    localparam logic [4:0] MN_JA     = 5'd5;
    localparam logic [4:0] MN_JMP    = 5'd6;
    localparam logic [4:0] MN_JMPFAR = 5'd7;
    localparam logic [4:0] MN_CALL   = 5'd8;
    localparam logic [4:0] MN_RET    = 5'd9;
    localparam logic [4:0] MN_PUSH   = 5'd10;
    localparam logic [4:0] MN_POP    = 5'd11;
    localparam logic [4:0] MN_MOV    = 5'd12;
    localparam logic [4:0] MN_MOVZX  = 5'd13;
    localparam logic [4:0] MN_LEA    = 5'd14;
    localparam logic [4:0] MN_ADD    = 5'd15;
    localparam logic [4:0] MN_SUB    = 5'd16;
    localparam logic [4:0] MN_XOR    = 5'd17;
    localparam logic [4:0] MN_CMP    = 5'd18;
    localparam logic [4:0] MN_TEST   = 5'd19;
    localparam logic [4:0] MN_NOP    = 5'd20;
    localparam logic [4:0] MN_SCAS   = 5'd21;
    localparam logic [4:0] MN_INT3   = 5'd22;
    localparam logic [4:0] MN_FS     = 5'd23;
    localparam logic [4:0] MN_REPZ   = 5'd24;

    localparam logic [3:0] OF_NONE   = 4'd0;
    localparam logic [3:0] OF_OPREG  = 4'd1;
    localparam logic [3:0] OF_REGREG = 4'd2;
    localparam logic [3:0] OF_RMD8   = 4'd3;
    localparam logic [3:0] OF_SIBD8  = 4'd4;
    localparam logic [3:0] OF_RMD32  = 4'd5;
    localparam logic [3:0] OF_ABS32  = 4'd6;
    localparam logic [3:0] OF_RM     = 4'd7;
    localparam logic [3:0] OF_RMIMM  = 4'd8;
    localparam logic [3:0] OF_MEMIMM = 4'd9;

    localparam logic [7:0] OP_ESC = 8'h0f;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       stream_start;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  mnemonic;
        logic [2:0]  instr_length;
        logic [7:0]  opcode_value;
        logic [7:0]  modrm_value;
        logic [7:0]  sib_value;
        logic [3:0]  operand_form;
        logic [31:0] displacement;
        logic [31:0] immediate;
        logic [15:0] far_selector;
    } out_beat_t;

    // Positions are byte offsets within the instruction; zero means absent
    // (offset zero never holds a field other than the opcode).
    typedef struct packed {
        logic [4:0] mn;
        logic [2:0] len;
        logic [3:0] form;
        logic       op_at;
        logic [1:0] modrm_at;
        logic [1:0] sib_at;
        logic [1:0] disp_at;
        logic [2:0] disp_n;
        logic [1:0] imm_at;
        logic [2:0] imm_n;
        logic       has_sel;
    } desc_t;

    // Entry handed from the classifier to the field extractor.
    typedef struct packed {
        desc_t       d;
        logic [55:0] bytes;
    } job_t;

endpackage
`default_nettype wire

[hw/rtl/xid_front.sv]
// Front end of the x86 subset decoder: collects code bytes and classifies
// each finished instruction into a descriptor. Depends on xid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xid_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  xid_pkg::in_beat_t s_data,
    output logic              job_valid,
    input  wire               job_ready,
    output xid_pkg::job_t     job
);

    logic [2:0]  idx_reg, idx_next;
    logic [47:0] held_reg, held_next;
    logic        halt_reg, halt_next;

    logic [2:0]  idx;
    logic [55:0] b;
    logic [2:0]  cnt;
    logic        need_more, bad, done;
    xid_pkg::desc_t d;
    logic [7:0]  op, m, b2;

    always_comb begin
        idx = s_data.stream_start ? 3'd0 : idx_reg;
        b = {8'd0, held_reg};
        b[idx*8 +: 8] = s_data.code_byte;
        cnt = idx + 3'd1;
        op = b[7:0];
        m  = b[15:8];
        b2 = b[23:16];
        d = '0;
        need_more = 1'b0;
        bad = 1'b0;
        if (op == xid_pkg::OP_ESC) begin
            d.op_at = 1'b1;
            if (cnt < 3'd2) begin
                need_more = 1'b1;
            end else begin
                unique case (m)
                    8'h84: begin
                        d.len = 3'd6; d.mn = xid_pkg::MN_JE;
                        d.disp_at = 2'd2; d.disp_n = 3'd4;
                    end
                    8'h85: begin
                        d.len = 3'd6; d.mn = xid_pkg::MN_JNE;
                        d.disp_at = 2'd2; d.disp_n = 3'd4;
                    end
                    8'h8c: begin
                        d.len = 3'd6; d.mn = xid_pkg::MN_JL;
                        d.disp_at = 2'd2; d.disp_n = 3'd4;
                    end
                    8'h8f: begin
                        d.len = 3'd6; d.mn = xid_pkg::MN_JG;
                        d.disp_at = 2'd2; d.disp_n = 3'd4;
                    end
                    8'hb7: begin
                        if (cnt < 3'd3) need_more = 1'b1;
                        else if (b2[7:6] != 2'b11) bad = 1'b1;
                        else begin
                            d.len = 3'd3; d.mn = xid_pkg::MN_MOVZX;
                            d.form = xid_pkg::OF_REGREG; d.modrm_at = 2'd2;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
        end else begin
            unique case (op)
                8'h50, 8'h51, 8'h55, 8'h56, 8'h57: begin
                    d.len = 3'd1; d.mn = xid_pkg::MN_PUSH; d.form = xid_pkg::OF_OPREG;
                end
                8'h59, 8'h5b, 8'h5d, 8'h5e, 8'h5f: begin
                    d.len = 3'd1; d.mn = xid_pkg::MN_POP; d.form = xid_pkg::OF_OPREG;
                end
                8'h64: begin d.len = 3'd1; d.mn = xid_pkg::MN_FS; end
                8'hf3: begin d.len = 3'd1; d.mn = xid_pkg::MN_REPZ; end
                8'h68: begin d.len = 3'd5; d.mn = xid_pkg::MN_PUSH; d.imm_at = 2'd1; d.imm_n = 3'd4; end
                8'h6a: begin d.len = 3'd2; d.mn = xid_pkg::MN_PUSH; d.imm_at = 2'd1; d.imm_n = 3'd1; end
                8'h74: begin d.len = 3'd2; d.mn = xid_pkg::MN_JE;  d.disp_at = 2'd1; d.disp_n = 3'd1; end
                8'h75: begin d.len = 3'd2; d.mn = xid_pkg::MN_JNE; d.disp_at = 2'd1; d.disp_n = 3'd1; end
                8'h77: begin d.len = 3'd2; d.mn = xid_pkg::MN_JA;  d.disp_at = 2'd1; d.disp_n = 3'd1; end
                8'heb: begin d.len = 3'd2; d.mn = xid_pkg::MN_JMP; d.disp_at = 2'd1; d.disp_n = 3'd1; end
                8'h90: begin d.len = 3'd1; d.mn = xid_pkg::MN_NOP; end
                8'ha1: begin
                    d.len = 3'd5; d.mn = xid_pkg::MN_MOV; d.form = xid_pkg::OF_ABS32;
                    d.disp_at = 2'd1; d.disp_n = 3'd4;
                end
                8'haf: begin d.len = 3'd1; d.mn = xid_pkg::MN_SCAS; end
                8'hb8: begin
                    d.len = 3'd5; d.mn = xid_pkg::MN_MOV; d.form = xid_pkg::OF_OPREG;
                    d.imm_at = 2'd1; d.imm_n = 3'd4;
                end
                8'hc2: begin d.len = 3'd3; d.mn = xid_pkg::MN_RET; d.imm_at = 2'd1; d.imm_n = 3'd2; end
                8'hc3: begin d.len = 3'd1; d.mn = xid_pkg::MN_RET; end
                8'hcc: begin d.len = 3'd1; d.mn = xid_pkg::MN_INT3; end
                8'he8: begin d.len = 3'd5; d.mn = xid_pkg::MN_CALL; d.disp_at = 2'd1; d.disp_n = 3'd4; end
                8'he9: begin d.len = 3'd5; d.mn = xid_pkg::MN_JMP;  d.disp_at = 2'd1; d.disp_n = 3'd4; end
                8'hea: begin
                    d.len = 3'd7; d.mn = xid_pkg::MN_JMPFAR;
                    d.disp_at = 2'd1; d.disp_n = 3'd4; d.has_sel = 1'b1;
                end
                8'h2b, 8'h33, 8'h3b, 8'h83, 8'h85, 8'h89, 8'h8b, 8'h8d, 8'hf7, 8'hff: begin
                    if (cnt < 3'd2) begin
                        need_more = 1'b1;
                    end else begin
                        d.modrm_at = 2'd1;
                        unique case (op)
                            8'h2b: begin
                                if ((m & 8'hc7) == 8'h44) begin
                                    d.len = 3'd4; d.mn = xid_pkg::MN_SUB; d.form = xid_pkg::OF_SIBD8;
                                    d.disp_at = 2'd3; d.disp_n = 3'd1; d.sib_at = 2'd2;
                                end else if (m[7:6] == 2'b11) begin
                                    d.len = 3'd2; d.mn = xid_pkg::MN_SUB; d.form = xid_pkg::OF_REGREG;
                                end else bad = 1'b1;
                            end
                            8'h33, 8'h3b, 8'h85: begin
                                d.mn = (op == 8'h33) ? xid_pkg::MN_XOR :
                                       (op == 8'h3b) ? xid_pkg::MN_CMP : xid_pkg::MN_TEST;
                                if (m[7:6] == 2'b01) begin
                                    d.len = 3'd3; d.form = xid_pkg::OF_RMD8;
                                    d.disp_at = 2'd2; d.disp_n = 3'd1;
                                end else if (m[7:6] == 2'b11) begin
                                    d.len = 3'd2; d.form = xid_pkg::OF_REGREG;
                                end else bad = 1'b1;
                            end
                            8'h83: begin
                                d.len = 3'd3; d.form = xid_pkg::OF_RMIMM;
                                d.imm_at = 2'd2; d.imm_n = 3'd1;
                                if ((m & 8'hf8) == 8'h78) begin
                                    d.len = 3'd4; d.mn = xid_pkg::MN_CMP; d.form = xid_pkg::OF_MEMIMM;
                                    d.disp_at = 2'd2; d.disp_n = 3'd1; d.imm_at = 2'd3;
                                end else if ((m & 8'hf8) == 8'hc0) d.mn = xid_pkg::MN_ADD;
                                else if ((m & 8'hf8) == 8'he8) d.mn = xid_pkg::MN_SUB;
                                else if ((m & 8'hf8) == 8'hf8) d.mn = xid_pkg::MN_CMP;
                                else bad = 1'b1;
                            end
                            8'h89: begin
                                d.mn = xid_pkg::MN_MOV;
                                if ((m & 8'hc7) == 8'h45) begin
                                    d.len = 3'd3; d.form = xid_pkg::OF_RMD8;
                                    d.disp_at = 2'd2; d.disp_n = 3'd1;
                                end else if ((m & 8'hc7) == 8'h05) begin
                                    d.len = 3'd6; d.form = xid_pkg::OF_ABS32;
                                    d.disp_at = 2'd2; d.disp_n = 3'd4;
                                end else if (m[7:6] == 2'b10) begin
                                    d.len = 3'd6; d.form = xid_pkg::OF_RMD32;
                                    d.disp_at = 2'd2; d.disp_n = 3'd4;
                                end else bad = 1'b1;
                            end
                            8'h8b: begin
                                d.mn = xid_pkg::MN_MOV;
                                unique case (m[7:6])
                                    2'b00: begin d.len = 3'd2; d.form = xid_pkg::OF_RM; end
                                    2'b11: begin d.len = 3'd2; d.form = xid_pkg::OF_REGREG; end
                                    2'b01: begin
                                        d.len = 3'd3; d.form = xid_pkg::OF_RMD8;
                                        d.disp_at = 2'd2; d.disp_n = 3'd1;
                                    end
                                    default: bad = 1'b1;
                                endcase
                            end
                            8'h8d: begin
                                d.mn = xid_pkg::MN_LEA;
                                if ((m & 8'hc7) == 8'h44) begin
                                    d.len = 3'd4; d.form = xid_pkg::OF_SIBD8;
                                    d.disp_at = 2'd3; d.disp_n = 3'd1; d.sib_at = 2'd2;
                                end else if (m[7:6] == 2'b01) begin
                                    d.len = 3'd3; d.form = xid_pkg::OF_RMD8;
                                    d.disp_at = 2'd2; d.disp_n = 3'd1;
                                end else if (m[7:6] == 2'b10) begin
                                    d.len = 3'd6; d.form = xid_pkg::OF_RMD32;
                                    d.disp_at = 2'd2; d.disp_n = 3'd4;
                                end else bad = 1'b1;
                            end
                            8'hf7: begin
                                if ((m & 8'hf8) == 8'h40) begin
                                    d.len = 3'd7; d.mn = xid_pkg::MN_TEST; d.form = xid_pkg::OF_MEMIMM;
                                    d.disp_at = 2'd2; d.disp_n = 3'd1;
                                    d.imm_at = 2'd3; d.imm_n = 3'd4;
                                end else bad = 1'b1;
                            end
                            default: begin
                                if ((m & 8'hf8) == 8'h70) begin
                                    d.len = 3'd3; d.mn = xid_pkg::MN_PUSH; d.form = xid_pkg::OF_RMD8;
                                    d.disp_at = 2'd2; d.disp_n = 3'd1;
                                end else bad = 1'b1;
                            end
                        endcase
                    end
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad) begin
            d = '0;
            d.mn = xid_pkg::MN_UNDEC;
            d.len = cnt;
        end
        done = bad || (!need_more && cnt >= d.len);
    end

    logic live;
    assign live = !(halt_reg && !s_data.stream_start);
    assign s_ready = job_ready;
    assign job_valid = s_valid && live && done;
    assign job.d = d;
    assign job.bytes = b;

    always_comb begin
        idx_next = idx_reg;
        held_next = held_reg;
        halt_next = halt_reg;
        if (s_valid && s_ready) begin
            if (s_data.stream_start) halt_next = 1'b0;
            if (live) begin
                if (done) begin
                    idx_next = 3'd0;
                    halt_next = bad;
                end else begin
                    idx_next = cnt;
                    held_next = b[47:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            held_reg <= '0;
            halt_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            held_reg <= held_next;
            halt_reg <= halt_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= 3'd6) else $error("byte index beyond held bytes");
    a_halt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> idx_reg == 3'd0) else $error("halted with partial instruction");
    a_undec_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && job_ready && d.mn == xid_pkg::MN_UNDEC) |=> halt_reg)
        else $error("undecodable beat did not halt");
`endif

endmodule
`default_nettype wire

[hw/rtl/xid_back.sv]
// Back end of the x86 subset decoder: a two-entry queue of descriptors and
// the field extractor with its output register. Depends on xid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xid_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                job_valid,
    output logic               job_ready,
    input  xid_pkg::job_t      job,
    output logic               m_valid,
    input  wire                m_ready,
    output xid_pkg::out_beat_t m_data
);

    xid_pkg::job_t q_reg [xid_pkg::QueueDepth];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    xid_pkg::out_beat_t out_reg;

    logic push, pop;
    xid_pkg::job_t h;
    xid_pkg::out_beat_t f;

    assign job_ready = cnt_reg != 2'(xid_pkg::QueueDepth);
    assign push = job_valid && job_ready;
    assign pop = cnt_reg != 2'd0 && (!ov_reg || m_ready);
    assign h = q_reg[rp_reg];

    function automatic logic [31:0] le(input logic [55:0] b, input logic [2:0] at,
                                       input logic [2:0] n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < n && at + i < xid_pkg::HeldBytes) v[i*8 +: 8] = b[(at + i)*8 +: 8];
        end
        return v;
    endfunction

    always_comb begin
        f = '0;
        f.mnemonic = h.d.mn;
        f.instr_length = h.d.len;
        f.opcode_value = h.d.op_at ? h.bytes[15:8] : h.bytes[7:0];
        if (h.d.mn != xid_pkg::MN_UNDEC) begin
            f.operand_form = h.d.form;
            if (h.d.modrm_at != 2'd0) f.modrm_value = h.bytes[h.d.modrm_at*8 +: 8];
            if (h.d.sib_at != 2'd0) f.sib_value = h.bytes[h.d.sib_at*8 +: 8];
            if (h.d.disp_at != 2'd0)
                f.displacement = le(h.bytes, {1'b0, h.d.disp_at}, h.d.disp_n);
            if (h.d.imm_at != 2'd0)
                f.immediate = le(h.bytes, {1'b0, h.d.imm_at}, h.d.imm_n);
            if (h.d.has_sel) f.far_selector = h.bytes[55:40];
        end
    end

    always_comb begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        ov_next = pop ? 1'b1 : (m_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= job;
        if (pop) out_reg <= f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
            ov_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(xid_pkg::QueueDepth)) else $error("queue over capacity");
    a_ptr_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers disagree with count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

[hw/rtl/x86_subset_instruction_decoder_core.sv]
// Top level of the byte-serial x86 subset instruction decoder.
// Instantiates xid_front and xid_back; types from xid_pkg.
// After its last code byte is accepted, a result is held in the queue and
// then in the output register.
// Throughput: one code byte per cycle, sustained, while results are taken.
// Rate is set by the combinational classifier; reset (aresetn, synchronous,
// active low) clears partial state and queue.
`timescale 1ns / 1ps
`default_nettype none
module x86_subset_instruction_decoder_core (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  xid_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output xid_pkg::out_beat_t m_data
);

    // The front end classifies each incoming beat against the bytes held so
    // far; a finished instruction is pushed as a descriptor into the queue.
    logic          job_valid, job_ready;
    xid_pkg::job_t job;

    xid_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // The back end pulls the fields out and holds the result beat in a register,
    // so the input side keeps flowing while a result waits, until the queue fills.
    xid_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
